/* hw/rtl/rdpg_pkg.sv */
`timescale 1ns / 1ps

package rdpg_pkg;

  // field and register widths
  localparam int PIX_W      = 16;
  localparam int CENTER_W   = 20;
  localparam int RADIUS_W   = 19;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int GAIN_W     = 17;
  localparam int CHAN_W     = 16;
  localparam int CHANS      = 4;
  localparam int QUOT_W     = CHAN_W;
  localparam int NUM_W      = R2_W + QUOT_W;
  localparam int SHALLOW_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CENTER_W;

  // depth maxima, written as (x << n) - x for the numerator scaling
  localparam logic [CHAN_W-1:0] MAX_SHALLOW = 16'd255;
  localparam logic [CHAN_W-1:0] MAX_DEEP    = 16'd65535;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALPHA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 3'd7;

  // settings seen by the datapath
  typedef struct packed {
    logic signed [CENTER_W-1:0]        center_x;
    logic signed [CENTER_W-1:0]        center_y;
    logic [R2_W-1:0]                   r2;
    logic [CHANS-1:0][GAIN_W-1:0]      gain;
    logic                              depth_mode;
  } rdpg_cfg_t;

endpackage

/* hw/rtl/rdpg_dist.sv */
`timescale 1ns / 1ps

module rdpg_dist
  import rdpg_pkg::*;
#(
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic signed [PIX_W-1:0]  pixel_x,
  input  logic signed [PIX_W-1:0]  pixel_y,
  input  rdpg_cfg_t                cfg,
  output logic                     out_valid,
  output logic                     out_inside,
  output logic [R2_W-1:0]          out_diff
);

  localparam int PosW   = PIX_W + SUBPIXEL_BITS;
  localparam int DiffW  = ((PosW > CENTER_W) ? PosW : CENTER_W) + 1;
  localparam int SqW    = 2 * DiffW;
  localparam int D2W    = SqW + 1;
  localparam int CmpW   = ((D2W > R2_W) ? D2W : R2_W) + 1;
  localparam int Stages = 5;

  logic [Stages-1:0]        valid_r;
  logic signed [DiffW-1:0]  px_ext, py_ext, cx_ext, cy_ext;
  logic signed [DiffW-1:0]  dx_r, dy_r;
  logic [DiffW-1:0]         mx_r, my_r;
  logic [SqW-1:0]           sqx_r, sqy_r;
  logic [D2W-1:0]           d2_r;
  logic [CmpW-1:0]          gap;
  logic                     inside_r;
  logic [R2_W-1:0]          diff_r;

  // pixel position in subpixel units against the center
  assign px_ext = DiffW'(pixel_x) <<< SUBPIXEL_BITS;
  assign py_ext = DiffW'(pixel_y) <<< SUBPIXEL_BITS;
  assign cx_ext = DiffW'(cfg.center_x);
  assign cy_ext = DiffW'(cfg.center_y);

  // r2 - d2, positive only strictly inside the disc
  assign gap = CmpW'(cfg.r2) - CmpW'(d2_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ce) begin
      valid_r <= {valid_r[Stages-2:0], in_valid};
    end
  end

  // offset, magnitude, square, sum, compare
  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r     <= px_ext - cx_ext;
      dy_r     <= py_ext - cy_ext;
      mx_r     <= dx_r[DiffW-1] ? $unsigned(-dx_r) : $unsigned(dx_r);
      my_r     <= dy_r[DiffW-1] ? $unsigned(-dy_r) : $unsigned(dy_r);
      sqx_r    <= SqW'(mx_r) * SqW'(mx_r);
      sqy_r    <= SqW'(my_r) * SqW'(my_r);
      d2_r     <= D2W'(sqx_r) + D2W'(sqy_r);
      inside_r <= !gap[CmpW-1] && (gap != '0);
      diff_r   <= gap[R2_W-1:0];
    end
  end

  assign out_valid  = valid_r[Stages-1];
  assign out_inside = inside_r;
  assign out_diff   = diff_r;

  // a pixel inside the disc always leaves a nonzero margin
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[Stages-1] && inside_r) |-> (diff_r != '0))
    else $error("inside pixel with zero margin");

endmodule

/* hw/rtl/rdpg_div.sv */
`timescale 1ns / 1ps

module rdpg_div
  import rdpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  logic               in_inside,
  input  logic [R2_W-1:0]    in_diff,
  input  logic [R2_W-1:0]    r2,
  input  logic               depth_mode,
  output logic               out_valid,
  output logic [QUOT_W-1:0]  out_base
);

  logic [NUM_W-1:0]   num;
  logic [QUOT_W:0]    valid_r;
  logic [QUOT_W:0]    inside_r;
  logic [R2_W-1:0]    rem_r  [0:QUOT_W];
  logic [QUOT_W-1:0]  word_r [0:QUOT_W];
  logic [R2_W:0]      shifted [0:QUOT_W-1];
  logic [R2_W+1:0]    trial   [0:QUOT_W-1];
  logic [QUOT_W-1:0]  take;

  // margin times the depth maximum, by shift and subtract
  always_comb begin
    if (depth_mode) begin
      num = (NUM_W'(in_diff) << CHAN_W) - NUM_W'(in_diff);
    end else begin
      num = (NUM_W'(in_diff) << SHALLOW_W) - NUM_W'(in_diff);
    end
  end

  // one restoring step per stage: shift in a numerator bit, try r2
  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      shifted[k] = {rem_r[k], word_r[k][QUOT_W-1]};
      trial[k]   = {1'b0, shifted[k]} - {2'b00, r2};
      take[k]    = !trial[k][R2_W+1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ce) begin
      valid_r <= {valid_r[QUOT_W-1:0], in_valid};
    end
  end

  // divider stages; word carries numerator bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (ce) begin
      inside_r  <= {inside_r[QUOT_W-1:0], in_inside};
      rem_r[0]  <= num[NUM_W-1:QUOT_W];
      word_r[0] <= num[QUOT_W-1:0];
      for (int k = 0; k < QUOT_W; k++) begin
        rem_r[k+1]  <= take[k] ? trial[k][R2_W-1:0] : shifted[k][R2_W-1:0];
        word_r[k+1] <= {word_r[k][QUOT_W-2:0], take[k]};
      end
    end
  end

  assign out_valid = valid_r[QUOT_W];
  assign out_base  = inside_r[QUOT_W] ? word_r[QUOT_W] : '0;

  // a stall freezes every stage
  assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> (valid_r == $past(valid_r)))
    else $error("divider stages moved during stall");

endmodule

/* hw/rtl/rdpg_gain.sv */
`timescale 1ns / 1ps

module rdpg_gain
  import rdpg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [QUOT_W-1:0]             in_base,
  input  logic [CHANS-1:0][GAIN_W-1:0]  gain,
  input  logic                          depth_mode,
  output logic                          out_valid,
  output logic [CHANS-1:0][CHAN_W-1:0]  out_chan
);

  localparam int ProdW = QUOT_W + GAIN_W;

  logic                          prod_valid_r;
  logic [ProdW-1:0]              prod_r [0:CHANS-1];
  logic [ProdW-1:0]              scaled [0:CHANS-1];
  logic [CHAN_W-1:0]             maxv;
  logic [CHANS-1:0][CHAN_W-1:0]  sat;
  logic                          out_valid_r;
  logic [CHANS-1:0][CHAN_W-1:0]  out_chan_r;

  // drop the fraction and clamp at the depth maximum
  assign maxv = depth_mode ? MAX_DEEP : MAX_SHALLOW;

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      scaled[c] = prod_r[c] >> FRAC_BITS;
      sat[c]    = (scaled[c] > ProdW'(maxv)) ? maxv : scaled[c][CHAN_W-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (ce) begin
      prod_valid_r <= in_valid;
      out_valid_r  <= prod_valid_r;
    end
  end

  // per-channel gain multiply, then output register
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < CHANS; c++) begin
        prod_r[c] <= ProdW'(in_base) * ProdW'(gain[c]);
      end
      out_chan_r <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_chan  = out_chan_r;

  // 8-bit mode never produces a value above 255
  assert property (@(posedge clk) disable iff (!rst_n)
    (ce && prod_valid_r && !depth_mode) |=>
      (out_chan_r[0][CHAN_W-1:SHALLOW_W] == '0) &&
      (out_chan_r[1][CHAN_W-1:SHALLOW_W] == '0) &&
      (out_chan_r[2][CHAN_W-1:SHALLOW_W] == '0) &&
      (out_chan_r[3][CHAN_W-1:SHALLOW_W] == '0))
    else $error("8-bit channel value out of range");

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ce) |=> (out_valid_r && $stable(out_chan_r)))
    else $error("held result changed");

endmodule

/* hw/rtl/radial_dot_pixel_generator_unit.sv */
`timescale 1ns / 1ps

// Radial dot pixel generator: one pixel coordinate in, four channel values out,
// one pixel per clock while out_tready does not stall, through 5 distance stages,
// one numerator scaling stage, 16 quotient stages of the divider, a gain
// multiply stage and the output register. The divider resolves one quotient
// bit per stage, which sets the depth of the pipeline. All stages advance
// together whenever the output register is empty or being taken, so a stall
// on out_tready holds every request in flight and in_tready follows it.
// Settings are meant to be written only while no pixel is in flight.
module radial_dot_pixel_generator_unit
  import rdpg_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // pixel_x, pixel_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [63:0]            out_tdata,  // chan0, chan1, chan2, chan3
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic                          ce;
  logic signed [CENTER_W-1:0]    center_x_r, center_y_r;
  logic [RADIUS_W-1:0]           radius_r;
  logic [R2_W-1:0]               r2_r;
  logic [CHANS-1:0][GAIN_W-1:0]  gain_r;
  logic                          depth_r;
  rdpg_cfg_t                     cfg;
  logic signed [PIX_W-1:0]       pixel_x, pixel_y;
  logic                          dist_valid, dist_inside;
  logic [R2_W-1:0]               dist_diff;
  logic                          div_valid;
  logic [QUOT_W-1:0]             div_base;
  logic [CHANS-1:0][CHAN_W-1:0]  chan;

  // global advance
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
      gain_r     <= {CHANS{GAIN_UNITY}};
      depth_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   center_x_r <= $signed(cfg_wdata);
        REG_CENTER_Y:   center_y_r <= $signed(cfg_wdata);
        REG_RADIUS:     radius_r   <= cfg_wdata[RADIUS_W-1:0];
        REG_GAIN_RED:   gain_r[0]  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_GREEN: gain_r[1]  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_BLUE:  gain_r[2]  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_ALPHA: gain_r[3]  <= cfg_wdata[GAIN_W-1:0];
        REG_DEPTH_MODE: depth_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // squared radius, settles long before a pixel reaches the compare
  always_ff @(posedge clk) begin
    r2_r <= R2_W'(radius_r) * R2_W'(radius_r);
  end

  assign cfg = '{center_x:   center_x_r,
                 center_y:   center_y_r,
                 r2:         r2_r,
                 gain:       gain_r,
                 depth_mode: depth_r};

  assign pixel_x = $signed(in_tdata[PIX_W-1:0]);
  assign pixel_y = $signed(in_tdata[2*PIX_W-1:PIX_W]);

  rdpg_dist #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (in_tvalid),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .cfg        (cfg),
    .out_valid  (dist_valid),
    .out_inside (dist_inside),
    .out_diff   (dist_diff)
  );

  rdpg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (dist_valid),
    .in_inside  (dist_inside),
    .in_diff    (dist_diff),
    .r2         (cfg.r2),
    .depth_mode (cfg.depth_mode),
    .out_valid  (div_valid),
    .out_base   (div_base)
  );

  rdpg_gain #(
    .FRAC_BITS(FRAC_BITS)
  ) u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (div_valid),
    .in_base    (div_base),
    .gain       (cfg.gain),
    .depth_mode (cfg.depth_mode),
    .out_valid  (out_tvalid),
    .out_chan   (chan)
  );

  assign out_tdata = chan;

endmodule
